/* rtl/tssu_pkg.sv */
// Package for the triangle scanline span unit: widths, register codes and the
// side-band record that travels beside the divider chains. No dependencies.
`default_nettype none

package tssu_pkg;

	localparam int COORD_BITS = 16;
	localparam int CW         = COORD_BITS;
	localparam int NUM_W      = 2 * CW;
	localparam int EXT_W      = (CW > 12) ? CW : 12;
	localparam int CFG_W      = 13;
	localparam int IDX_W      = 2;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [11:0]    row;
		logic [7:0]     red;
		logic [7:0]     green;
		logic [7:0]     blue;
		logic           live;
		logic           bottom;
		logic [CW-1:0]  hb;
		logic [CW-1:0]  hbt;
		logic [NUM_W-1:0] x2t;
		logic [CW-1:0]  eb;
	} tssu_side_t;

endpackage

`default_nettype wire

/* rtl/triangle_scanline_span_unit.sv */
// Top level of the triangle scanline span unit: vertex sort, edge setup,
// products, two division chains in parallel, a third chain, and the clamp.
// Depends on tssu_pkg and tssu_div_chain.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_ready    vertices, scan_row, color
//   out      from block out_valid / out_ready  span_valid, row, ends, fill
//   cfg      to block   cfg_we                 cfg_index, cfg_data
//
// One beat enters per cycle unless the output stalls. Path: sort, setup,
// multiply and add stages, 2 * COORD_BITS division cells, each giving one
// quotient bit, three stages between the two division rows, output register.
// Reset clears all stage valid bits and loads the frame size to 640 by 480.
// Every stage holds its beat only while the one after it is full and stalled,
// so bubbles close up and the input keeps taking beats behind a stalled result.
`default_nettype none

module triangle_scanline_span_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [tssu_pkg::IDX_W-1:0]   cfg_index,
	input  wire [tssu_pkg::CFG_W-1:0]   cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [15:0]                  vert0_x,
	input  wire [15:0]                  vert0_y,
	input  wire [15:0]                  vert1_x,
	input  wire [15:0]                  vert1_y,
	input  wire [15:0]                  vert2_x,
	input  wire [15:0]                  vert2_y,
	input  wire [11:0]                  scan_row,
	input  wire [7:0]                   color_red,
	input  wire [7:0]                   color_green,
	input  wire [7:0]                   color_blue,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        span_valid,
	output logic [11:0]                 span_row,
	output logic [11:0]                 span_left,
	output logic [11:0]                 span_right,
	output logic [7:0]                  fill_red,
	output logic [7:0]                  fill_green,
	output logic [7:0]                  fill_blue
);
	import tssu_pkg::*;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: sort by y ----------------
	logic [CW-1:0] ax0, ay0, ax1, ay1, ax2, ay2;
	logic [CW-1:0] bx0, by0, bx2, by2, bx1, by1;
	logic [CW-1:0] cx1, cy1, cx2, cy2;
	logic          v_s1, r_s1;
	logic [CW-1:0] x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1;
	logic [11:0]   row_s1;
	logic [7:0]    red_s1, grn_s1, blu_s1;

	always_comb begin
		ax0 = vert0_x[CW-1:0]; ay0 = vert0_y[CW-1:0];
		ax1 = vert1_x[CW-1:0]; ay1 = vert1_y[CW-1:0];
		ax2 = vert2_x[CW-1:0]; ay2 = vert2_y[CW-1:0];
		if (ay0 > ay1) begin
			bx0 = ax1; by0 = ay1; bx1 = ax0; by1 = ay0;
		end else begin
			bx0 = ax0; by0 = ay0; bx1 = ax1; by1 = ay1;
		end
		bx2 = ax2; by2 = ay2;
		if (by0 > by2) begin
			cx1 = bx2; cy1 = by2; cx2 = bx0; cy2 = by0;
		end else begin
			cx1 = bx0; cy1 = by0; cx2 = bx2; cy2 = by2;
		end
	end

	logic v_s2, r_s2;
	assign r_s1     = !v_s1 || r_s2;
	assign in_ready = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (r_s1) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (r_s1 && in_valid) begin
			x0_s1 <= cx1; y0_s1 <= cy1;
			if (by1 > cy2) begin
				x1_s1 <= cx2; y1_s1 <= cy2; x2_s1 <= bx1; y2_s1 <= by1;
			end else begin
				x1_s1 <= bx1; y1_s1 <= by1; x2_s1 <= cx2; y2_s1 <= cy2;
			end
			row_s1 <= scan_row;
			red_s1 <= color_red; grn_s1 <= color_green; blu_s1 <= color_blue;
		end
	end

	// ---------------- stage 2: edge setup ----------------
	logic [EXT_W-1:0] row_e, y0_e, y1_e, y2_e, t0_e, t1_e;
	logic [CW-1:0]    t0, t1, hl, h01, hb, tl, et, eh;
	logic             top, bot, live;
	logic [CW-1:0] la_s2, lb_s2, lc_s2, ld_s2, lh_s2;
	logic [CW-1:0] ea_s2, eb_s2, ec_s2, ed_s2, eh_s2;
	logic [CW-1:0] hb_s2, hbt_s2, x2_s2, t1_s2;
	logic          live_s2, bot_s2;
	logic [11:0]   row_s2;
	logic [7:0]    red_s2, grn_s2, blu_s2;

	always_comb begin
		row_e = EXT_W'(row_s1);
		y0_e  = EXT_W'(y0_s1);
		y1_e  = EXT_W'(y1_s1);
		y2_e  = EXT_W'(y2_s1);
		t0_e  = row_e - y0_e;
		t1_e  = row_e - y1_e;
		t0    = t0_e[CW-1:0];
		t1    = t1_e[CW-1:0];
		hl    = y2_s1 - y0_s1;
		h01   = y1_s1 - y0_s1;
		hb    = y2_s1 - y1_s1;
		top   = (row_e >= y0_e) && (row_e < y1_e);
		bot   = (row_e >= y1_e) && (row_e < y2_e);
		live  = (y0_s1 != y2_s1) && ({1'b0, row_s1} < frame_height_q) &&
			(top || bot) && (frame_width_q != '0);
		// Top part reads the long edge at the row; bottom part needs the split x.
		tl    = top ? t0 : h01;
		et    = top ? t0 : t1;
		eh    = top ? h01 : hb;
	end

	logic v_s3, r_s3;
	assign r_s2 = !v_s2 || r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (r_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (r_s2 && v_s1) begin
			la_s2 <= x0_s1; lb_s2 <= hl - tl; lc_s2 <= x2_s1; ld_s2 <= tl; lh_s2 <= hl;
			ea_s2 <= top ? x0_s1 : x1_s1;
			eb_s2 <= eh - et;
			ec_s2 <= top ? x1_s1 : x2_s1;
			ed_s2 <= et;
			eh_s2 <= eh;
			hb_s2 <= hb; hbt_s2 <= hb - t1; x2_s2 <= x2_s1; t1_s2 <= t1;
			live_s2 <= live; bot_s2 <= !top;
			row_s2 <= row_s1; red_s2 <= red_s1; grn_s2 <= grn_s1; blu_s2 <= blu_s1;
		end
	end

	// ---------------- stage 3: products ----------------
	logic [NUM_W-1:0] pl1_s3, pl2_s3, pe1_s3, pe2_s3, px_s3;
	logic [CW-1:0]    lh_s3, eh_s3, hb_s3, hbt_s3;
	logic             live_s3, bot_s3;
	logic [11:0]      row_s3;
	logic [7:0]       red_s3, grn_s3, blu_s3;

	logic v_s4, r_s4;
	assign r_s3 = !v_s3 || r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (r_s3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (r_s3 && v_s2) begin
			pl1_s3 <= la_s2 * lb_s2;
			pl2_s3 <= lc_s2 * ld_s2;
			pe1_s3 <= ea_s2 * eb_s2;
			pe2_s3 <= ec_s2 * ed_s2;
			px_s3  <= x2_s2 * t1_s2;
			lh_s3 <= lh_s2; eh_s3 <= eh_s2; hb_s3 <= hb_s2; hbt_s3 <= hbt_s2;
			live_s3 <= live_s2; bot_s3 <= bot_s2;
			row_s3 <= row_s2; red_s3 <= red_s2; grn_s3 <= grn_s2; blu_s3 <= blu_s2;
		end
	end

	// ---------------- stage 4: numerators ----------------
	logic [NUM_W-1:0] nl_s4, ne_s4;
	logic [CW-1:0]    lh_s4, eh_s4;
	tssu_side_t       sa_s4, sb_s4;
	logic             a_in_rdy, b_in_rdy;

	assign r_s4 = !v_s4 || (a_in_rdy && b_in_rdy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (r_s4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (r_s4 && v_s3) begin
			nl_s4 <= pl1_s3 + pl2_s3;
			ne_s4 <= pe1_s3 + pe2_s3;
			lh_s4 <= lh_s3;
			eh_s4 <= eh_s3;
			sa_s4 <= '{row: '0, red: '0, green: '0, blue: '0, live: live_s3,
				bottom: bot_s3, hb: hb_s3, hbt: hbt_s3, x2t: px_s3, eb: '0};
			sb_s4 <= '{row: row_s3, red: red_s3, green: grn_s3, blue: blu_s3,
				live: 1'b0, bottom: 1'b0, hb: '0, hbt: '0, x2t: '0, eb: '0};
		end
	end

	// ---------------- long edge and short edge division ----------------
	logic          a_out_v, b_out_v, ab_rdy;
	logic [CW-1:0] ql, qe;
	tssu_side_t    sa_out, sb_out;

	tssu_div_chain u_div_long (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4), .in_ready(a_in_rdy),
		.in_num(nl_s4), .in_div(lh_s4), .in_side(sa_s4),
		.out_valid(a_out_v), .out_ready(ab_rdy),
		.out_quo(ql), .out_side(sa_out)
	);

	tssu_div_chain u_div_short (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4), .in_ready(b_in_rdy),
		.in_num(ne_s4), .in_div(eh_s4), .in_side(sb_s4),
		.out_valid(b_out_v), .out_ready(ab_rdy),
		.out_quo(qe), .out_side(sb_out)
	);

	// ---------------- stage 5: capture quotients ----------------
	logic          v_s5, r_s5;
	logic [CW-1:0] ql_s5;
	tssu_side_t    sd_s5;
	logic          v_s6, r_s6;

	assign r_s5   = !v_s5 || r_s6;
	assign ab_rdy = r_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (r_s5) v_s5 <= a_out_v && b_out_v;
	end

	always_ff @(posedge clk) begin
		if (r_s5 && a_out_v && b_out_v) begin
			ql_s5 <= ql;
			sd_s5 <= '{row: sb_out.row, red: sb_out.red, green: sb_out.green,
				blue: sb_out.blue, live: sa_out.live, bottom: sa_out.bottom,
				hb: sa_out.hb, hbt: sa_out.hbt, x2t: sa_out.x2t, eb: qe};
		end
	end

	// ---------------- stage 6: split-x product ----------------
	// In the top part the long-edge quotient passes through a divide by one.
	logic [NUM_W-1:0] m_s6;
	tssu_side_t       sd_s6;
	logic             v_s7, r_s7;

	assign r_s6 = !v_s6 || r_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (r_s6) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (r_s6 && v_s5) begin
			m_s6  <= ql_s5 * (sd_s5.bottom ? sd_s5.hbt : CW'(1));
			sd_s6 <= sd_s5;
		end
	end

	// ---------------- stage 7: bottom edge numerator ----------------
	logic [NUM_W-1:0] n_s7;
	logic [CW-1:0]    d_s7;
	tssu_side_t       sd_s7;
	logic             c_in_rdy;

	assign r_s7 = !v_s7 || c_in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (r_s7) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (r_s7 && v_s6) begin
			n_s7  <= m_s6 + (sd_s6.bottom ? sd_s6.x2t : '0);
			d_s7  <= sd_s6.bottom ? sd_s6.hb : CW'(1);
			sd_s7 <= sd_s6;
		end
	end

	logic          c_out_v, r_s8;
	logic [CW-1:0] qa;
	tssu_side_t    sc_out;

	tssu_div_chain u_div_edge (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s7), .in_ready(c_in_rdy),
		.in_num(n_s7), .in_div(d_s7), .in_side(sd_s7),
		.out_valid(c_out_v), .out_ready(r_s8),
		.out_quo(qa), .out_side(sc_out)
	);

	// ---------------- stage 8: order, clamp, output register ----------------
	logic             v_s8;
	logic [EXT_W-1:0] lo, hi, hic, lim;
	logic [CFG_W-1:0] wm1;
	logic             ok;

	always_comb begin
		lo  = (qa < sc_out.eb) ? EXT_W'(qa) : EXT_W'(sc_out.eb);
		hi  = (qa < sc_out.eb) ? EXT_W'(sc_out.eb) : EXT_W'(qa);
		wm1 = frame_width_q - CFG_W'(1);
		lim = (wm1 > CFG_W'(4095)) ? EXT_W'(12'd4095) : EXT_W'(wm1[11:0]);
		hic = (hi > lim) ? lim : hi;
		ok  = sc_out.live && (lo <= hic);
	end

	assign r_s8 = !v_s8 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (r_s8) v_s8 <= c_out_v;
	end

	always_ff @(posedge clk) begin
		if (r_s8 && c_out_v) begin
			span_valid <= ok;
			span_row   <= sc_out.row;
			span_left  <= ok ? lo[11:0] : 12'd0;
			span_right <= ok ? hic[11:0] : 12'd0;
			fill_red   <= sc_out.red;
			fill_green <= sc_out.green;
			fill_blue  <= sc_out.blue;
		end
	end

	assign out_valid = v_s8;

`ifndef SYNTHESIS
	a_chains_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		a_out_v == b_out_v)
		else $error("long and short edge dividers out of step");

	a_span_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_valid |-> span_left <= span_right)
		else $error("span left end past right end");

	a_span_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_valid |-> {1'b0, span_row} < frame_height_q &&
		{1'b0, span_right} < frame_width_q)
		else $error("span outside the frame");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !span_valid |-> span_left == 12'd0 && span_right == 12'd0)
		else $error("empty span with nonzero ends");
`endif

endmodule

`default_nettype wire

/* rtl/tssu_div_cell.sv */
// One restoring-division cell: produces one quotient bit per beat.
// Depends on tssu_pkg.
`default_nettype none

module tssu_div_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire [tssu_pkg::CW-1:0]  in_rem,
	input  wire [tssu_pkg::CW-1:0]  in_word,
	input  wire [tssu_pkg::CW-1:0]  in_div,
	input  wire tssu_pkg::tssu_side_t in_side,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [tssu_pkg::CW-1:0] out_rem,
	output logic [tssu_pkg::CW-1:0] out_word,
	output logic [tssu_pkg::CW-1:0] out_div,
	output tssu_pkg::tssu_side_t    out_side
);
	import tssu_pkg::*;

	logic [CW:0] trial;
	logic [CW:0] diff;
	logic        ge;
	logic        valid_q;
	logic [CW-1:0] rem_q, word_q, div_q;
	tssu_side_t  side_q;

	// The word holds the numerator bits still to come at the top and the
	// quotient bits already found at the bottom.
	assign trial = {in_rem, in_word[CW-1]};
	assign ge    = trial >= {1'b0, in_div};
	assign diff  = trial - {1'b0, in_div};

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
			word_q <= {in_word[CW-2:0], ge};
			div_q  <= in_div;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_word  = word_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

/* rtl/tssu_div_chain.sv */
// Row of division cells, one quotient bit per cell, for quotients that fit
// in CW bits. Depends on tssu_pkg and tssu_div_cell.
`default_nettype none

module tssu_div_chain (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [tssu_pkg::NUM_W-1:0]  in_num,
	input  wire [tssu_pkg::CW-1:0]     in_div,
	input  wire tssu_pkg::tssu_side_t  in_side,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [tssu_pkg::CW-1:0]    out_quo,
	output tssu_pkg::tssu_side_t       out_side
);
	import tssu_pkg::*;

	logic          vld  [0:CW];
	logic          rdy  [0:CW];
	logic [CW-1:0] rem  [0:CW];
	logic [CW-1:0] word [0:CW];
	logic [CW-1:0] dv   [0:CW];
	tssu_side_t    sd   [0:CW];

	// The quotient fits in CW bits, so the upper half of the numerator is
	// already below the divisor and serves as the first remainder.
	assign vld[0]  = in_valid;
	assign in_ready = rdy[0];
	assign rem[0]  = in_num[NUM_W-1:CW];
	assign word[0] = in_num[CW-1:0];
	assign dv[0]   = in_div;
	assign sd[0]   = in_side;

	for (genvar i = 0; i < CW; i++) begin : g_cell
		tssu_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[i]),
			.in_ready (rdy[i]),
			.in_rem   (rem[i]),
			.in_word  (word[i]),
			.in_div   (dv[i]),
			.in_side  (sd[i]),
			.out_valid(vld[i+1]),
			.out_ready(rdy[i+1]),
			.out_rem  (rem[i+1]),
			.out_word (word[i+1]),
			.out_div  (dv[i+1]),
			.out_side (sd[i+1])
		);
	end

	assign rdy[CW]   = out_ready;
	assign out_valid = vld[CW];
	assign out_quo   = word[CW];
	assign out_side  = sd[CW];

endmodule

`default_nettype wire

/* dv/triangle_scanline_span_unit_tb.sv */
// Testbench for the triangle scanline span unit: drives vertex and row beats,
// predicts each span with exact integer math and checks results in order.
// Depends on tssu_pkg and the RTL of triangle_scanline_span_unit.
`timescale 1ns / 1ps

module triangle_scanline_span_unit_tb;
	import tssu_pkg::*;

	typedef struct {
		logic        ok;
		logic [11:0] row;
		logic [11:0] left;
		logic [11:0] right;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} span_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [15:0] vert0_x = 0, vert0_y = 0, vert1_x = 0, vert1_y = 0, vert2_x = 0, vert2_y = 0;
	logic [11:0] scan_row = 0;
	logic [7:0] color_red = 0, color_green = 0, color_blue = 0;
	logic out_valid;
	logic out_ready = 0;
	logic span_valid;
	logic [11:0] span_row, span_left, span_right;
	logic [7:0] fill_red, fill_green, fill_blue;

	triangle_scanline_span_unit dut (.*);

	always #5 clk = ~clk;

	span_t expected_spans[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;
	logic [12:0] width_reg = FRAME_WIDTH_RST;
	logic [12:0] height_reg = FRAME_HEIGHT_RST;

	function automatic logic [63:0] edge_at(logic [63:0] xa, logic [63:0] xb,
		logic [63:0] t, logic [63:0] h);
		return (xa * (h - t) + xb * t) / h;
	endfunction

	function automatic span_t predict_span(logic [15:0] v [6], logic [11:0] row,
		logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [63:0] x0, y0, x1, y1, x2, y2, tmp, ea, eb, lo, hi, lim, xs;
		logic in_tri;
		span_t s;
		x0 = v[0]; y0 = v[1]; x1 = v[2]; y1 = v[3]; x2 = v[4]; y2 = v[5];
		if (y0 > y1) begin
			tmp = y0; y0 = y1; y1 = tmp; tmp = x0; x0 = x1; x1 = tmp;
		end
		if (y0 > y2) begin
			tmp = y0; y0 = y2; y2 = tmp; tmp = x0; x0 = x2; x2 = tmp;
		end
		if (y1 > y2) begin
			tmp = y1; y1 = y2; y2 = tmp; tmp = x1; x1 = x2; x2 = tmp;
		end
		in_tri = 0; ea = 0; eb = 0;
		if (y0 != y2 && row < height_reg) begin
			if (row >= y0 && row < y1) begin
				ea = edge_at(x0, x2, row - y0, y2 - y0);
				eb = edge_at(x0, x1, row - y0, y1 - y0);
				in_tri = 1;
			end else if (row >= y1 && row < y2) begin
				xs = edge_at(x0, x2, y1 - y0, y2 - y0);
				ea = edge_at(xs, x2, row - y1, y2 - y1);
				eb = edge_at(x1, x2, row - y1, y2 - y1);
				in_tri = 1;
			end
		end
		s.ok = 0; s.left = 0; s.right = 0;
		if (in_tri && width_reg != 0) begin
			lo = (ea < eb) ? ea : eb;
			hi = (ea < eb) ? eb : ea;
			lim = width_reg - 1;
			if (lim > 4095) lim = 4095;
			if (hi > lim) hi = lim;
			if (lo <= hi) begin
				s.ok = 1; s.left = lo[11:0]; s.right = hi[11:0];
			end
		end
		s.row = row; s.r = r; s.g = g; s.b = b;
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// The receiver side: stall pattern, plus a long hold-off when asked.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("triangle_scanline_span_unit test failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_spans.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				span_t e;
				e = expected_spans.pop_front();
				if (span_valid !== e.ok) report_mismatch("span_valid", span_valid, e.ok);
				if (span_row !== e.row) report_mismatch("span_row", span_row, e.row);
				if (span_left !== e.left) report_mismatch("span_left", span_left, e.left);
				if (span_right !== e.right) report_mismatch("span_right", span_right, e.right);
				if (fill_red !== e.r) report_mismatch("fill_red", fill_red, e.r);
				if (fill_green !== e.g) report_mismatch("fill_green", fill_green, e.g);
				if (fill_blue !== e.b) report_mismatch("fill_blue", fill_blue, e.b);
			end
		end
	end

	// Sends one beat; the expectation is queued at the accepting edge.
	// Valid stays high on return so that the next beat can follow at once.
	task automatic send_span_query(logic [15:0] v [6], logic [11:0] row,
		logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		scan_row <= row; color_red <= r; color_green <= g; color_blue <= b;
		vert0_x <= v[0]; vert0_y <= v[1]; vert1_x <= v[2];
		vert1_y <= v[3]; vert2_x <= v[4]; vert2_y <= v[5];
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		expected_spans.push_back(predict_span(v, row, r, g, b));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_spans.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_frame(logic [12:0] w, logic [12:0] h);
		drain();
		cfg_we <= 1; cfg_index <= REG_FRAME_WIDTH; cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_FRAME_HEIGHT; cfg_data <= h;
		@(negedge clk);
		cfg_we <= 0;
		width_reg = w; height_reg = h;
	endtask

	task automatic send_random(int n, int small_coords);
		logic [15:0] v [6];
		logic [11:0] row;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 6; k++)
				v[k] = small_coords ? 16'($urandom_range(700)) : 16'($urandom);
			// With small coordinates, mostly ask for a row within the coordinate range.
			if (small_coords && $urandom_range(3) != 0)
				row = 12'($urandom_range(0, 700));
			else
				row = 12'($urandom);
			send_span_query(v, row, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_directed();
		logic [15:0] v [6];
		// Flat triangle.
		v = '{10, 20, 50, 20, 90, 20};
		send_span_query(v, 20, 8'hff, 0, 8'hff);
		// Top part, bottom part, the split row and the excluded last row.
		v = '{100, 10, 10, 50, 300, 90};
		send_span_query(v, 10, 1, 2, 3);
		send_span_query(v, 30, 4, 5, 6);
		send_span_query(v, 50, 7, 8, 9);
		send_span_query(v, 70, 10, 11, 12);
		send_span_query(v, 90, 13, 14, 15);
		send_span_query(v, 9, 16, 17, 18);
		// Unsorted order exercising every swap.
		v = '{300, 90, 10, 50, 100, 10};
		send_span_query(v, 60, 8'haa, 8'h55, 0);
		// Row at and beyond frame height.
		v = '{0, 0, 4000, 4000, 0, 4095};
		send_span_query(v, 479, 0, 0, 0);
		send_span_query(v, 480, 0, 0, 0);
		send_span_query(v, 4095, 8'hff, 8'hff, 8'hff);
		// Span wholly right of the frame, and clamp at the right edge.
		v = '{1000, 0, 2000, 100, 1500, 200};
		send_span_query(v, 50, 1, 1, 1);
		v = '{0, 0, 60000, 100, 0, 200};
		send_span_query(v, 100, 2, 2, 2);
		// Extreme coordinates.
		v = '{16'hffff, 16'hffff, 0, 0, 16'hffff, 0};
		send_span_query(v, 4095, 3, 3, 3);
		send_span_query(v, 0, 3, 3, 3);
	endtask

	task automatic test_frame_sizes();
		write_frame(4096, 4096);
		send_random(60, 0);
		send_random(60, 1);
		write_frame(1, 1);
		send_random(40, 1);
		write_frame(0, 4096);
		send_random(30, 1);
		write_frame(8191, 0);
		send_random(30, 1);
		write_frame(8191, 8191);
		send_random(60, 0);
		write_frame(640, 480);
	endtask

	task automatic test_idle_phases();
		send_idle = 0; recv_stall = 0; send_random(300, 1);
		send_idle = 74; recv_stall = 0; send_random(250, 1);
		send_idle = 0; recv_stall = 74; send_random(250, 0);
		send_idle = 9; recv_stall = 9; send_random(300, 1);
		send_idle = 0; recv_stall = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		send_random(120, 1);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_frame_sizes();
		test_idle_phases();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("triangle_scanline_span_unit test passed");
		else
			$display("triangle_scanline_span_unit test failed");
		$finish;
	end

endmodule
